// ===== rtl/ptft_pkg.sv =====
// Shared types, constants and helper functions of the pan/tilt face tracker.
`default_nettype none
package ptft_pkg;

	localparam logic signed [17:0] PAN_LOW   = 18'sd0;
	localparam logic signed [17:0] PAN_HIGH  = 18'sd11520;
	localparam logic signed [17:0] TILT_LOW  = 18'sd0;
	localparam logic signed [17:0] TILT_HIGH = 18'sd11520;

	localparam int DIV_STEPS = 27;
	localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

	localparam logic [2:0] REG_PAN_CENTER  = 3'd0;
	localparam logic [2:0] REG_TILT_CENTER = 3'd1;
	localparam logic [2:0] REG_PAN_GAIN    = 3'd2;
	localparam logic [2:0] REG_TILT_GAIN   = 3'd3;
	localparam logic [2:0] REG_DEAD_BAND   = 3'd4;
	localparam logic [2:0] REG_STEP_LIMIT  = 3'd5;
	localparam logic [2:0] REG_HOME_STEP   = 3'd6;
	localparam logic [2:0] REG_LOST_TMO    = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ERR,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic err_en;
		logic mul_en;
		logic upd_en;
		logic out_load;
	} dp_cmd_t;

	function automatic logic signed [17:0] clamp18(input logic signed [17:0] v,
			input logic signed [17:0] lo, input logic signed [17:0] hi);
		logic signed [17:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic signed [17:0] step18(input logic signed [17:0] cur,
			input logic signed [17:0] target, input logic signed [17:0] lim);
		logic signed [17:0] d;
		logic signed [17:0] r;
		d = target - cur;
		r = target;
		if (d > lim) begin
			r = cur + lim;
		end else if (d < -lim) begin
			r = cur - lim;
		end
		return r;
	endfunction

	localparam logic [15:0] PAN_RESET  = 16'(clamp18(18'sd5760, PAN_LOW, PAN_HIGH));
	localparam logic [15:0] TILT_RESET = 16'(clamp18(18'sd5760, TILT_LOW, TILT_HIGH));

endpackage
`default_nettype wire

// ===== rtl/ptft_if.sv =====
// Handshake channels for detection events and angle results.
`default_nettype none
interface ptft_evt_if;
	logic        valid;
	logic        ready;
	logic        box_present;
	logic [11:0] left_edge;
	logic [11:0] top_edge;
	logic [11:0] right_edge;
	logic [11:0] bottom_edge;
	logic [11:0] frame_width;
	logic [11:0] frame_height;
	logic [31:0] time_ms;
	modport source (output valid, box_present, left_edge, top_edge, right_edge,
		bottom_edge, frame_width, frame_height, time_ms, input ready);
	modport sink (input valid, box_present, left_edge, top_edge, right_edge,
		bottom_edge, frame_width, frame_height, time_ms, output ready);
endinterface

interface ptft_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pan_angle;
	logic signed [15:0] tilt_angle;
	logic               locked;
	modport source (output valid, pan_angle, tilt_angle, locked, input ready);
	modport sink (input valid, pan_angle, tilt_angle, locked, output ready);
endinterface
`default_nettype wire

// ===== rtl/pan_tilt_face_tracker.sv =====
// Top level of the pan/tilt face tracker: controller plus datapath.
// Usage: one detection event enters on the evt channel (valid/ready transfer);
// for each event exactly one result (pan_angle, tilt_angle, locked) leaves on
// the res channel. Events are processed one at a time.
// Processing: an accepted event passes through the two parallel restoring
// dividers, one quotient bit per cycle over 27 bits, then through the
// registered error, multiply and angle-update steps before its result
// is loaded into the output register when the result channel is free.
// The result sits in an output register; a new event is accepted while a
// previous result still waits. If the receiver stalls, the next result waits
// in the controller's done state and no further event is taken until the
// output register can be loaded.
// Reset (arst_n low) restores all configuration registers to their defaults,
// sets both angles to their centers clamped to the limits, clears the
// last-seen time and the seen flag, and drops res valid.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered in the datapath.
`default_nettype none
module pan_tilt_face_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ptft_evt_if.sink         evt,
	ptft_res_if.source       res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	ptft_pkg::dp_cmd_t cmd;

	ptft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.cmd       (cmd)
	);

	ptft_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.box_present  (evt.box_present),
		.left_edge    (evt.left_edge),
		.top_edge     (evt.top_edge),
		.right_edge   (evt.right_edge),
		.bottom_edge  (evt.bottom_edge),
		.frame_width  (evt.frame_width),
		.frame_height (evt.frame_height),
		.time_ms      (evt.time_ms),
		.pan_angle    (res.pan_angle),
		.tilt_angle   (res.tilt_angle),
		.locked       (res.locked)
	);
endmodule
`default_nettype wire

// ===== rtl/ptft_ctrl.sv =====
// Sequencer of the tracker: steps the datapath through divide, error, multiply and update.
`default_nettype none
module ptft_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             evt_valid,
	output logic                  evt_ready,
	input  wire logic             res_ready,
	output logic                  res_valid,
	output ptft_pkg::dp_cmd_t     cmd
);
	ptft_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic       res_valid_q;
	logic       slot_free;

	assign slot_free = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptft_pkg::ST_IDLE: if (evt_valid) state_d = ptft_pkg::ST_DIV;
			ptft_pkg::ST_DIV:  if (cnt_q == ptft_pkg::DIV_LAST) state_d = ptft_pkg::ST_ERR;
			ptft_pkg::ST_ERR:  state_d = ptft_pkg::ST_MUL;
			ptft_pkg::ST_MUL:  state_d = ptft_pkg::ST_UPD;
			ptft_pkg::ST_UPD:  state_d = ptft_pkg::ST_DONE;
			ptft_pkg::ST_DONE: if (slot_free) state_d = ptft_pkg::ST_IDLE;
			default:           state_d = ptft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		evt_ready = 1'b0;
		case (state_q)
			ptft_pkg::ST_IDLE: begin
				evt_ready = 1'b1;
				cmd.load = evt_valid;
			end
			ptft_pkg::ST_DIV:  cmd.div_step = 1'b1;
			ptft_pkg::ST_ERR:  cmd.err_en = 1'b1;
			ptft_pkg::ST_MUL:  cmd.mul_en = 1'b1;
			ptft_pkg::ST_UPD:  cmd.upd_en = 1'b1;
			ptft_pkg::ST_DONE: cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptft_pkg::ST_IDLE;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ptft_pkg::ST_DIV && cnt_q != ptft_pkg::DIV_LAST) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_cnt_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ptft_pkg::ST_DIV) |-> (cnt_q == 5'd0))
		else $error("divide counter runs outside the divide phase");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt_ready) |=> (state_q == ptft_pkg::ST_DIV))
		else $error("accepted transfer did not start the divide");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> res_valid_q)
		else $error("result load did not raise valid");
endmodule
`default_nettype wire

// ===== rtl/ptft_dp.sv =====
// Datapath of the tracker: registers, two serial dividers, gain multiply and angle update.
`default_nettype none
module ptft_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ptft_pkg::dp_cmd_t  cmd,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               box_present,
	input  wire logic [11:0]        left_edge,
	input  wire logic [11:0]        top_edge,
	input  wire logic [11:0]        right_edge,
	input  wire logic [11:0]        bottom_edge,
	input  wire logic [11:0]        frame_width,
	input  wire logic [11:0]        frame_height,
	input  wire logic [31:0]        time_ms,
	output logic signed [15:0]      pan_angle,
	output logic signed [15:0]      tilt_angle,
	output logic                    locked
);
	logic [13:0] pan_center_q, tilt_center_q, step_limit_q, home_step_q;
	logic [15:0] pan_gain_q, tilt_gain_q;
	logic [14:0] dead_band_q;
	logic [31:0] lost_tmo_q;

	logic [15:0] pan_now_q, tilt_now_q;
	logic [31:0] last_seen_q;
	logic        seen_once_q;

	logic        valid_q;
	logic [31:0] time_q;
	logic [11:0] wid_q, hgt_q;
	logic [11:0] remx_q, remy_q;
	logic [26:0] quox_q, quoy_q;
	logic signed [16:0] errx_q, erry_q;
	logic signed [33:0] prodx_q, prody_q;
	logic        dzx_q, dzy_q;

	logic [12:0] trx, try_;
	logic        gex, gey;
	logic [12:0] sumx, sumy;
	logic signed [16:0] ex, ey;
	logic signed [17:0] corrx, corry, limit, hstep;
	logic signed [17:0] newpan, newtilt;

	function automatic logic signed [16:0] to_err(input logic [26:0] q);
		logic signed [16:0] e;
		if (q > 27'd49152) begin
			e = -17'sd32768;
		end else begin
			e = 17'sd16384 - signed'({1'b0, q[15:0]});
		end
		return e;
	endfunction

	function automatic logic dead(input logic signed [16:0] e, input logic [14:0] db);
		logic [16:0] mag;
		mag = (e < 0) ? 17'(-e) : 17'(e);
		return mag <= {2'b0, db};
	endfunction

	function automatic logic signed [17:0] corr(input logic signed [33:0] p);
		logic signed [33:0] t;
		t = (p < 0) ? (p + 34'sd32767) : p;
		return 18'(t >>> 15);
	endfunction

	assign sumx = {1'b0, left_edge} + {1'b0, right_edge};
	assign sumy = {1'b0, top_edge} + {1'b0, bottom_edge};
	assign trx = {remx_q, quox_q[26]};
	assign try_ = {remy_q, quoy_q[26]};
	assign gex = trx >= {1'b0, wid_q};
	assign gey = try_ >= {1'b0, hgt_q};
	assign ex = to_err(quox_q);
	assign ey = to_err(quoy_q);
	assign corrx = corr(prodx_q);
	assign corry = corr(prody_q);
	assign limit = signed'({4'b0, step_limit_q});
	assign hstep = signed'({4'b0, home_step_q});

	always_comb begin
		newpan = signed'({2'b0, pan_now_q});
		newtilt = signed'({2'b0, tilt_now_q});
		if (valid_q) begin
			newpan = ptft_pkg::clamp18(ptft_pkg::step18(newpan,
				dzx_q ? newpan : newpan + corrx, limit), ptft_pkg::PAN_LOW, ptft_pkg::PAN_HIGH);
			newtilt = ptft_pkg::clamp18(ptft_pkg::step18(newtilt,
				dzy_q ? newtilt : newtilt + corry, limit), ptft_pkg::TILT_LOW,
				ptft_pkg::TILT_HIGH);
		end else if (seen_once_q && (time_q - last_seen_q) >= lost_tmo_q) begin
			newpan = ptft_pkg::step18(newpan, signed'({4'b0, pan_center_q}), hstep);
			newtilt = ptft_pkg::step18(newtilt, signed'({4'b0, tilt_center_q}), hstep);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_center_q <= 14'd5760;
			tilt_center_q <= 14'd5760;
			pan_gain_q <= 16'd1280;
			tilt_gain_q <= 16'd1280;
			dead_band_q <= 15'd1638;
			step_limit_q <= 14'd192;
			home_step_q <= 14'd64;
			lost_tmo_q <= 32'd1500;
			pan_now_q <= ptft_pkg::PAN_RESET;
			tilt_now_q <= ptft_pkg::TILT_RESET;
			last_seen_q <= '0;
			seen_once_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptft_pkg::REG_PAN_CENTER:  pan_center_q <= cfg_data[13:0];
					ptft_pkg::REG_TILT_CENTER: tilt_center_q <= cfg_data[13:0];
					ptft_pkg::REG_PAN_GAIN:    pan_gain_q <= cfg_data[15:0];
					ptft_pkg::REG_TILT_GAIN:   tilt_gain_q <= cfg_data[15:0];
					ptft_pkg::REG_DEAD_BAND:   dead_band_q <= cfg_data[14:0];
					ptft_pkg::REG_STEP_LIMIT:  step_limit_q <= cfg_data[13:0];
					ptft_pkg::REG_HOME_STEP:   home_step_q <= cfg_data[13:0];
					ptft_pkg::REG_LOST_TMO:    lost_tmo_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.upd_en) begin
				pan_now_q <= newpan[15:0];
				tilt_now_q <= newtilt[15:0];
				if (valid_q) begin
					last_seen_q <= time_q;
					seen_once_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			valid_q <= box_present && frame_width != '0 && frame_height != '0
				&& right_edge > left_edge && bottom_edge > top_edge;
			time_q <= time_ms;
			wid_q <= frame_width;
			hgt_q <= frame_height;
			remx_q <= '0;
			remy_q <= '0;
			quox_q <= {sumx, 14'b0};
			quoy_q <= {sumy, 14'b0};
		end
		if (cmd.div_step) begin
			remx_q <= gex ? 12'(trx - {1'b0, wid_q}) : trx[11:0];
			remy_q <= gey ? 12'(try_ - {1'b0, hgt_q}) : try_[11:0];
			quox_q <= {quox_q[25:0], gex};
			quoy_q <= {quoy_q[25:0], gey};
		end
		if (cmd.err_en) begin
			errx_q <= ex;
			erry_q <= ey;
			dzx_q <= dead(ex, dead_band_q);
			dzy_q <= dead(ey, dead_band_q);
		end
		if (cmd.mul_en) begin
			prodx_q <= errx_q * signed'({1'b0, pan_gain_q});
			prody_q <= erry_q * signed'({1'b0, tilt_gain_q});
		end
		if (cmd.out_load) begin
			pan_angle <= pan_now_q;
			tilt_angle <= tilt_now_q;
			locked <= valid_q;
		end
	end
endmodule
`default_nettype wire
